// ----- rtl/sgrd_pkg.sv -----
// Shared types and constants for the subset gap-run decoder.
`default_nettype none
package sgrd_pkg;

   localparam int unsigned MaxElements = 65536;
   localparam logic [16:0] MAX_ELEMENTS_C = 17'(MaxElements);
   localparam logic [16:0] COUNT_RESET_C = 17'd65536;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW = $clog2(QueueDepth);

   // Configuration register indexes.
   localparam logic [1:0] REG_START_POSITION = 2'd0;
   localparam logic [1:0] REG_ELEMENT_COUNT = 2'd1;

   // One unit of work handed from the parser to the emitter.
   typedef struct packed {
      logic        is_end;
      logic [15:0] base;
      logic [7:0]  mask;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- rtl/sgrd_front.sv -----
// Byte parser: tracks groups and position, turns bitmap bytes into emit jobs.
`default_nettype none
module sgrd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [16:0]            csr_data,
   input  wire sgrd_pkg::queue_status_type q_status,
   output logic                        q_push,
   output sgrd_pkg::job_type           q_job
);
   import sgrd_pkg::*;

   typedef enum logic [1:0] {
      PH_GAP    = 2'd0,
      PH_COUNT  = 2'd1,
      PH_BITMAP = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [16:0] position_ff, position_in;
   logic        gap_zero_ff, gap_zero_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [16:0] start_ff;
   logic [16:0] count_ff;

   logic        accept;
   logic [16:0] limit;
   logic [16:0] remaining;
   logic [16:0] gap_sum;
   logic [16:0] start_clamped;
   logic [7:0]  valid_bits;
   logic [7:0]  hit_bits;
   logic        below_limit;

   assign req_tready = !q_status.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   assign limit         = (count_ff > MAX_ELEMENTS_C) ? MAX_ELEMENTS_C : count_ff;
   assign below_limit   = position_ff < limit;
   assign remaining     = limit - position_ff;
   assign gap_sum       = position_ff + 17'(req_tdata);
   assign start_clamped = (csr_data > MAX_ELEMENTS_C) ? MAX_ELEMENTS_C : csr_data;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         valid_bits[i] = below_limit && (remaining > 17'(i));
      end
   end

   assign hit_bits = req_tdata & valid_bits;

   always_comb begin
      phase_in      = phase_ff;
      position_in   = position_ff;
      gap_zero_in   = gap_zero_ff;
      bytes_left_in = bytes_left_ff;
      q_push        = 1'b0;
      q_job.is_end  = 1'b0;
      q_job.base    = position_ff[15:0];
      q_job.mask    = hit_bits;
      if (accept) begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (gap_zero_ff && req_tdata == 8'd0) begin
                  // End of set: report it and go back to the start position.
                  q_push        = 1'b1;
                  q_job.is_end  = 1'b1;
                  q_job.base    = 16'd0;
                  q_job.mask    = 8'd0;
                  phase_in      = PH_GAP;
                  position_in   = (start_ff > MAX_ELEMENTS_C) ? MAX_ELEMENTS_C : start_ff;
                  gap_zero_in   = 1'b0;
                  bytes_left_in = 8'd0;
               end else begin
                  bytes_left_in = req_tdata;
                  phase_in      = (req_tdata == 8'd0) ? PH_GAP : PH_BITMAP;
               end
            end
            PH_BITMAP: begin
               q_push = hit_bits != 8'd0;
               if (below_limit) begin
                  position_in = (remaining >= 17'd8) ? position_ff + 17'd8 : limit;
               end
               bytes_left_in = bytes_left_ff - 8'd1;
               if (bytes_left_in == 8'd0) begin
                  phase_in = PH_GAP;
               end
            end
            default: begin
               position_in = (gap_sum > MAX_ELEMENTS_C) ? MAX_ELEMENTS_C : gap_sum;
               gap_zero_in = req_tdata == 8'd0;
               phase_in    = PH_COUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_GAP;
         position_ff   <= 17'd0;
         gap_zero_ff   <= 1'b0;
         bytes_left_ff <= 8'd0;
         start_ff      <= 17'd0;
         count_ff      <= COUNT_RESET_C;
      end else if (csr_valid && csr_index == REG_START_POSITION) begin
         // A new start position restarts the parser.
         start_ff      <= csr_data;
         phase_ff      <= PH_GAP;
         position_ff   <= start_clamped;
         gap_zero_ff   <= 1'b0;
         bytes_left_ff <= 8'd0;
      end else begin
         if (csr_valid && csr_index == REG_ELEMENT_COUNT) begin
            count_ff <= csr_data;
         end
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         gap_zero_ff   <= gap_zero_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sgrd_queue.sv -----
// Small job queue between the parser and the emitter.
`default_nettype none
module sgrd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire sgrd_pkg::job_type       push_job,
   input  wire logic                    pop,
   output sgrd_pkg::job_type            head_job,
   output sgrd_pkg::queue_status_type   status
);
   import sgrd_pkg::*;

   job_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff;
   logic [QueuePtrW-1:0]   rd_ptr_ff;
   logic [QueuePtrW:0]     fill_ff;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = fill_ff == (QueuePtrW+1)'(QueueDepth);
   assign status.empty = fill_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sgrd_back.sv -----
// Emitter: walks the set bits of a job, one member index per transfer.
`default_nettype none
module sgrd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sgrd_pkg::queue_status_type q_status,
   input  wire sgrd_pkg::job_type       q_head,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [15:0]                  rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);
   import sgrd_pkg::*;

   logic        active_ff;
   job_type     job_ff;
   logic [2:0]  low_bit;
   logic [7:0]  mask_rest;
   logic        is_last;
   logic        done;

   // Lowest set bit first, as the bitmap is read LSB first.
   always_comb begin
      low_bit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (job_ff.mask[i]) begin
            low_bit = 3'(i);
         end
      end
   end

   assign mask_rest  = job_ff.mask & (job_ff.mask - 8'd1);
   assign is_last    = job_ff.is_end || (mask_rest == 8'd0);
   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = job_ff.is_end ? 16'd0 : job_ff.base + 16'(low_bit);
   assign rsp_tuser  = job_ff.is_end;
   assign rsp_tlast  = is_last;

   assign done  = !active_ff || (rsp_tready && is_last);
   assign q_pop = done && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (done) begin
         active_ff <= !q_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end else if (active_ff && rsp_tready) begin
         job_ff.mask <= mask_rest;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/subset_gap_run_decoder_unit.sv -----
// Top level of the subset gap-run decoder: parser, job queue and emitter.
// With the emitter idle, the first result of a byte passes through a job queue entry
// and then the emitter's job register before it can transfer.
// Throughput: one byte per cycle in while the job queue has room; the emitter sends one
// result per cycle while rsp_tready is high, so a bitmap byte with k members below the
// bound gives k results, up to eight. A four-entry job queue lets the parser run ahead.
// Synchronous active-high reset empties the queue and the emitter, puts the parser at
// position 0 expecting a gap byte, and loads start 0 and element count 65536.
`default_nettype none
module subset_gap_run_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] packed_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] member_index
   output logic             rsp_tuser,   // [0] result_kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_data
);
   import sgrd_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             q_push;
   logic             q_pop;

   sgrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   sgrd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   sgrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_head     (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- tb/subset_gap_run_decoder_unit_tb.sv -----
// Self-checking testbench for the subset gap-run decoder, with its own model of the decoding.
`timescale 1ns / 1ps
module subset_gap_run_decoder_unit_tb;
   import sgrd_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam logic KIND_MEMBER = 1'b0;
   localparam logic KIND_SET_END = 1'b1;
   // Indexes that the address field allows but that name no register.
   localparam logic [1:0] REG_SPARE_2 = 2'd2;
   localparam logic [1:0] REG_SPARE_3 = 2'd3;

   typedef enum logic [1:0] {
      PH_EXPECT_GAP = 2'd0,
      PH_EXPECT_COUNT = 2'd1,
      PH_BITMAP = 2'd2
   } parse_phase_type;

   typedef struct packed {
      logic [15:0] member_index;
      logic        result_kind;
      logic        last_of_run;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [16:0] csr_data = 17'd0;

   subset_gap_run_decoder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Decoder model state and configuration.
   logic [16:0]     mdl_start;
   logic [16:0]     mdl_count;
   parse_phase_type mdl_phase;
   logic [16:0]     mdl_position;
   logic            mdl_gap_zero;
   logic [7:0]      mdl_bytes_left;

   decoded_type pending_decodes[$];
   int errors = 0;
   int bytes_sent = 0;
   int tx_max_gap = 19;
   int rx_max_stall = 19;
   int rx_hold = 0;

   function automatic logic [16:0] clamp_to_max(input logic [17:0] v);
      return (v > {1'b0, MAX_ELEMENTS_C}) ? MAX_ELEMENTS_C : v[16:0];
   endfunction

   task automatic restart_model();
      mdl_phase = PH_EXPECT_GAP;
      mdl_position = clamp_to_max({1'b0, mdl_start});
      mdl_gap_zero = 1'b0;
      mdl_bytes_left = 8'd0;
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic [16:0] limit;
      int n;
      n = 0;
      case (mdl_phase)
         PH_EXPECT_COUNT: begin
            if (mdl_gap_zero && b == 8'd0) begin
               pending_decodes.push_back('{16'd0, KIND_SET_END, 1'b0});
               n = 1;
               restart_model();
            end else begin
               mdl_bytes_left = b;
               mdl_phase = (b == 8'd0) ? PH_EXPECT_GAP : PH_BITMAP;
            end
         end
         PH_BITMAP: begin
            limit = clamp_to_max({1'b0, mdl_count});
            // Once the position hits the bound, the remaining bits do nothing.
            for (int s = 0; s < 8; s++) begin
               if (mdl_position < limit) begin
                  if (b[s]) begin
                     pending_decodes.push_back('{mdl_position[15:0], KIND_MEMBER, 1'b0});
                     n++;
                  end
                  mdl_position = mdl_position + 17'd1;
               end
            end
            mdl_bytes_left = mdl_bytes_left - 8'd1;
            if (mdl_bytes_left == 8'd0) mdl_phase = PH_EXPECT_GAP;
         end
         default: begin
            mdl_position = clamp_to_max({1'b0, mdl_position} + {10'd0, b});
            mdl_gap_zero = (b == 8'd0);
            mdl_phase = PH_EXPECT_COUNT;
         end
      endcase
      if (n > 0) pending_decodes[pending_decodes.size() - 1].last_of_run = 1'b1;
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      decode_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_until_drained(input int extra);
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_START_POSITION) begin
         mdl_start = value;
         restart_model();
      end else if (idx == REG_ELEMENT_COUNT) begin
         mdl_count = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_bounds(input logic [16:0] start, input logic [16:0] count);
      wait_until_drained(12);
      write_reg(REG_ELEMENT_COUNT, count);
      write_reg(REG_START_POSITION, start);
   endtask

   function automatic logic [7:0] pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return 8'd0;
      if (r < 25) return 8'd255;
      return 8'($urandom_range(1, 40));
   endfunction

   function automatic logic [7:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 8'd0;
      if (r < 85) return 8'($urandom_range(1, 3));
      return 8'($urandom_range(4, 16));
   endfunction

   function automatic logic [7:0] pick_bitmap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 8'hFF;
      if (r < 30) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly well-formed sets; now and then leading junk or a missing terminator.
   task automatic send_random_set();
      int groups;
      int cnt;
      groups = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      repeat (groups) begin
         send_byte(pick_gap());
         cnt = pick_count();
         send_byte(8'(cnt));
         repeat (cnt) send_byte(pick_bitmap());
      end
      if ($urandom_range(0, 19) != 0) begin
         send_byte(8'd0);
         send_byte(8'd0);
      end
   endtask

   task automatic run_random_phase(input logic [16:0] start, input logic [16:0] count,
                                   input int tx_gap, input int rx_stall, input int n_bytes);
      int target;
      set_bounds(start, count);
      tx_max_gap = tx_gap;
      rx_max_stall = rx_stall;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_set();
   endtask

   // Empty set, empty group, group after a zero gap, dense and empty bitmaps.
   task automatic test_plain_groups();
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(8'd5);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(8'd2);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'd255);
      send_byte(8'd1);
      send_byte(8'hA5);
   endtask

   // Element bound reached mid-byte, start clamping, gap saturation, top index.
   task automatic test_bounds();
      set_bounds(17'd3, 17'd20);
      send_byte(8'd10);
      send_byte(8'd3);
      repeat (3) send_byte(8'hFF);
      send_byte(8'd0);
      send_byte(8'd0);
      set_bounds(17'h1FFFF, 17'd65536);
      send_byte(8'd255);
      send_byte(8'd1);
      send_byte(8'hFF);
      set_bounds(17'd65530, 17'h1FFFF);
      send_byte(8'd0);
      send_byte(8'd1);
      send_byte(8'hFF);
      send_byte(8'd0);
      send_byte(8'd0);
   endtask

   // Writes to unused indexes must leave the bounds and the parse state alone.
   task automatic test_spare_indexes();
      set_bounds(17'd0, 17'd65536);
      send_byte(8'd7);
      wait_until_drained(12);
      write_reg(REG_SPARE_2, 17'($urandom_range(0, 131071)));
      write_reg(REG_SPARE_3, 17'($urandom_range(0, 131071)));
      send_byte(8'd1);
      send_byte(8'h81);
   endtask

   task automatic test_random_sets();
      run_random_phase(17'd0, 17'd65536, 19, 19, 70);
      run_random_phase(17'($urandom_range(0, 300)), 17'($urandom_range(0, 600)), 0, 0, 70);
      run_random_phase(17'($urandom_range(32768, 65535)), 17'd65536, 19, 19, 70);
      run_random_phase(17'd0, 17'h1FFFF, 19, 5, 70);
      run_random_phase(17'($urandom_range(0, 1000)), 17'd0, 5, 19, 70);
   endtask

   // The receiver stops for a long while so the job queue fills and input stalls.
   task automatic test_output_backpressure();
      set_bounds(17'd0, 17'd65536);
      tx_max_gap = 0;
      rx_max_stall = 3;
      rx_hold = 300;
      send_byte(8'd1);
      send_byte(8'd40);
      repeat (40) send_byte(8'hFF);
      send_byte(8'd0);
      send_byte(8'd0);
   endtask

   // The sender stops mid-group until every pending result has come out.
   task automatic test_sender_pause();
      tx_max_gap = 19;
      rx_max_stall = 19;
      send_byte(8'd2);
      send_byte(8'd4);
      send_byte(8'h3C);
      send_byte(8'h81);
      wait_until_drained(0);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'd0);
      send_byte(8'd0);
   endtask

   initial begin : receiver
      int stall;
      forever begin
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rx_hold) @(negedge clock);
            rx_hold = 0;
         end
         stall = (rx_max_stall > 0) ? $urandom_range(0, rx_max_stall) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_decodes.size() == 0) begin
            $error("unexpected result: member_index=%0d result_kind=%0b last_of_run=%0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = pending_decodes.pop_front();
            if (rsp_tdata !== want.member_index) begin
               $error("member_index: expected %0d, got %0d", want.member_index, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.result_kind) begin
               $error("result_kind: expected %0b, got %0b", want.result_kind, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", want.last_of_run, rsp_tlast);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : sequencer
      mdl_start = 17'd0;
      mdl_count = COUNT_RESET_C;
      restart_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_plain_groups();
      test_bounds();
      test_spare_indexes();
      test_random_sets();
      test_output_backpressure();
      test_sender_pause();
      wait_until_drained(20);
      if (pending_decodes.size() != 0) begin
         $error("%0d expected results never arrived", pending_decodes.size());
         errors++;
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
